### hw/rtl/mhpq_pkg.sv
// Shared types, sizes and codes for the min-heap priority queue.
// Used by the channel interfaces, the level cell, the level RAM and the top level.
// Depends on nothing.
package mhpq_pkg;

	localparam int HEAP_DEPTH  = 1024;
	localparam int VALUE_W     = 32;
	localparam int COUNT_OUT_W = 11;

	// Heap levels needed to hold HEAP_DEPTH entries; level 0 is the root.
	localparam int LEVELS = $clog2(HEAP_DEPTH + 1);
	// Position of a node inside the deepest level.
	localparam int POS_W  = LEVELS - 1;
	// Global slot index, wide enough for the first grandchild below the last level.
	localparam int GIDX_W = LEVELS + 1;
	localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
	localparam int LVL_W  = $clog2(LEVELS);

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_RUN,
		S_DONE
	} state_t;

	// Operation travelling down the row of level cells.
	// Push: pos is the node at the receiving level, rem the levels still to descend,
	// path the target slot plus one (its bits below the leading one steer the walk).
	// Pop: pos is the hole at the level above, base the global index of the first
	// node at the receiving level, count the entry count after the pop.
	typedef struct packed {
		logic              valid;
		op_t               op;
		value_t            carry;
		logic [POS_W-1:0]  pos;
		logic [LVL_W-1:0]  rem;
		logic [GIDX_W-1:0] path;
		logic [GIDX_W-1:0] base;
		logic [CNT_W-1:0]  count;
	} token_t;

	// Write handed back from a cell to the level above it.
	typedef struct packed {
		logic             en;
		logic [POS_W-1:0] pos;
		value_t           value;
	} bwr_t;

	// Port requests of a cell toward its level RAM.
	typedef struct packed {
		logic [POS_W-1:0] raddr0;
		logic [POS_W-1:0] raddr1;
		logic             we;
		logic [POS_W-1:0] waddr;
		value_t           wdata;
	} ram_req_t;

endpackage

### hw/rtl/mhpq_req_if.sv
// Request channel of the min-heap priority queue: valid/ready plus operation and value.
// Depends on mhpq_pkg.
interface mhpq_req_if;
	logic                valid;
	logic                ready;
	mhpq_pkg::op_t       operation;
	mhpq_pkg::value_t    value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

### hw/rtl/mhpq_rsp_if.sv
// Result channel of the min-heap priority queue: valid/ready plus the result fields.
// Depends on mhpq_pkg.
interface mhpq_rsp_if;
	logic                                valid;
	logic                                ready;
	mhpq_pkg::value_t                    top_value;
	logic                                is_empty;
	logic [mhpq_pkg::COUNT_OUT_W-1:0]    entry_count;
	mhpq_pkg::status_t                   result_status;

	modport source (output valid, output top_value, output is_empty, output entry_count,
		output result_status, input ready);
	modport sink   (input valid, input top_value, input is_empty, input entry_count,
		input result_status, output ready);
endinterface

### hw/rtl/mhpq_ram.sv
// Storage of one heap level: one write port, two registered read ports.
// Depends on mhpq_pkg for the value type.
module mhpq_ram #(
	parameter int ADDR_W = 1
) (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  mhpq_pkg::value_t   wdata,
	input  logic [ADDR_W-1:0]  raddr0,
	input  logic [ADDR_W-1:0]  raddr1,
	output mhpq_pkg::value_t   rdata0,
	output mhpq_pkg::value_t   rdata1
);

	localparam int ROWS = 1 << ADDR_W;

	mhpq_pkg::value_t mem [ROWS];
	mhpq_pkg::value_t rdata0_q;
	mhpq_pkg::value_t rdata1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0_q <= mem[raddr0];
		rdata1_q <= mem[raddr1];
	end

	assign rdata0 = rdata0_q;
	assign rdata1 = rdata1_q;

endmodule

### hw/rtl/mhpq_cell.sv
// One heap level below the root: compare-and-pass logic for push and pop.
// Depends on mhpq_pkg; its level RAM is instantiated next to it in the top level.
module mhpq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  mhpq_pkg::token_t    tok_in,
	output mhpq_pkg::token_t    tok_out,
	input  mhpq_pkg::bwr_t      bwr_in,
	output mhpq_pkg::bwr_t      bwr_out,
	output mhpq_pkg::ram_req_t  ram,
	input  mhpq_pkg::value_t    rdata0,
	input  mhpq_pkg::value_t    rdata1,
	output logic                done
);

	mhpq_pkg::token_t                  hold_q;
	mhpq_pkg::token_t                  fwd_q;
	mhpq_pkg::token_t                  fwd_d;
	logic                              push_here;
	logic                              own_we;
	logic [mhpq_pkg::POS_W-1:0]        own_waddr;
	mhpq_pkg::value_t                  own_wdata;
	logic [mhpq_pkg::GIDX_W-1:0]       left_g;
	logic [mhpq_pkg::GIDX_W-1:0]       kid_g;
	logic [mhpq_pkg::GIDX_W-1:0]       grand_g;
	logic                              right_ok;
	logic                              pick_right;
	mhpq_pkg::value_t                  kid_val;
	logic [mhpq_pkg::POS_W-1:0]        kid_pos;

	// A push that has reached its target level just writes the carried value.
	assign push_here = tok_in.valid && (tok_in.op == mhpq_pkg::OP_PUSH) && (tok_in.rem == '0);

	// Push reads its own node; pop reads both children of the hole above.
	always_comb begin
		ram.raddr0 = (tok_in.op == mhpq_pkg::OP_POP) ? (tok_in.pos << 1) : tok_in.pos;
		ram.raddr1 = (tok_in.pos << 1) | mhpq_pkg::POS_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			fwd_q  <= '0;
		end else begin
			hold_q       <= tok_in;
			hold_q.valid <= tok_in.valid && !push_here;
			fwd_q        <= fwd_d;
		end
	end

	always_comb begin
		left_g     = hold_q.base + mhpq_pkg::GIDX_W'({hold_q.pos, 1'b0});
		right_ok   = (left_g + mhpq_pkg::GIDX_W'(1)) < mhpq_pkg::GIDX_W'(hold_q.count);
		pick_right = right_ok && (rdata1 < rdata0);
		kid_val    = pick_right ? rdata1 : rdata0;
		kid_g      = left_g + mhpq_pkg::GIDX_W'(pick_right);
		grand_g    = {kid_g[mhpq_pkg::GIDX_W-2:0], 1'b1};
		kid_pos    = (hold_q.pos << 1) | mhpq_pkg::POS_W'(pick_right);

		fwd_d       = hold_q;
		fwd_d.valid = 1'b0;
		own_we      = push_here;
		own_waddr   = tok_in.pos;
		own_wdata   = tok_in.carry;
		bwr_out     = '0;
		done        = push_here;

		if (hold_q.valid) begin
			if (hold_q.op == mhpq_pkg::OP_PUSH) begin
				// Keep the smaller value here and carry the larger one down the path.
				fwd_d.valid = 1'b1;
				fwd_d.rem   = hold_q.rem - 1'b1;
				fwd_d.pos   = (hold_q.pos << 1) |
					mhpq_pkg::POS_W'(hold_q.path[hold_q.rem - 1'b1]);
				if (hold_q.carry < rdata0) begin
					own_we      = 1'b1;
					own_waddr   = hold_q.pos;
					own_wdata   = hold_q.carry;
					fwd_d.carry = rdata0;
				end
			end else begin
				if (kid_val < hold_q.carry) begin
					// The smaller child moves up and the hole moves down to it.
					bwr_out.en    = 1'b1;
					bwr_out.pos   = hold_q.pos;
					bwr_out.value = kid_val;
					if (grand_g < mhpq_pkg::GIDX_W'(hold_q.count)) begin
						fwd_d.valid = 1'b1;
						fwd_d.pos   = kid_pos;
						fwd_d.base  = {hold_q.base[mhpq_pkg::GIDX_W-2:0], 1'b1};
					end else begin
						own_we    = 1'b1;
						own_waddr = kid_pos;
						own_wdata = hold_q.carry;
						done      = 1'b1;
					end
				end else begin
					bwr_out.en    = 1'b1;
					bwr_out.pos   = hold_q.pos;
					bwr_out.value = hold_q.carry;
					done          = 1'b1;
				end
			end
		end
	end

	// Writes handed back from the level below never coincide with this level's own.
	always_comb begin
		ram.we    = own_we || bwr_in.en;
		ram.waddr = bwr_in.en ? bwr_in.pos : own_waddr;
		ram.wdata = bwr_in.en ? bwr_in.value : own_wdata;
	end

	assign tok_out = fwd_q;

endmodule

### hw/rtl/min_heap_priority_queue.sv
// Top level of the min-heap priority queue: root register, controller, level cells.
// Depends on mhpq_pkg, mhpq_req_if, mhpq_rsp_if, mhpq_cell and mhpq_ram.

// The queue holds up to HEAP_DEPTH signed 32-bit values as a binary min-heap and
// answers every request with one result: the minimum after the operation (zero when
// empty), an empty flag, the entry count and a status. A push to a full heap or a pop
// from an empty one is refused with its status code and leaves the heap unchanged.
// The root lives in a register; every deeper level is a cell with a RAM of its own,
// and a request walks down the row of cells one level at a time, each level doing
// a registered RAM read, then a compare and write that hands the request to the
// next cell. One request is worked on at a time; the next one is accepted as soon
// as the previous result sits in the output register, even while that result is
// still waiting to be taken. No memory clearing is needed after reset: entries
// beyond the count are never read.
module min_heap_priority_queue (
	input  logic         clk,
	input  logic         arst_n,
	mhpq_req_if.sink     req,
	mhpq_rsp_if.source   rsp
);

	mhpq_pkg::state_t                  state_q;
	mhpq_pkg::state_t                  state_d;
	logic [mhpq_pkg::CNT_W-1:0]        count_q;
	mhpq_pkg::value_t                  root_q;
	mhpq_pkg::status_t                 status_q;
	logic [mhpq_pkg::LVL_W-1:0]        fetch_lvl;
	logic [mhpq_pkg::LVL_W-1:0]        fetch_lvl_q;
	logic                              fetch_sel;
	logic                              accept;
	logic                              load_rsp;
	logic [mhpq_pkg::GIDX_W-1:0]       np1;
	logic [mhpq_pkg::LVL_W-1:0]        push_lvl;
	mhpq_pkg::token_t                  push_tok;
	mhpq_pkg::token_t                  pop_tok;
	mhpq_pkg::token_t                  launch_q;

	mhpq_pkg::token_t                  tok   [1:mhpq_pkg::LEVELS];
	mhpq_pkg::bwr_t                    bwr   [1:mhpq_pkg::LEVELS];
	mhpq_pkg::ram_req_t                ram   [1:mhpq_pkg::LEVELS-1];
	mhpq_pkg::value_t                  rdat0 [0:mhpq_pkg::LEVELS-1];
	mhpq_pkg::value_t                  rdat1 [1:mhpq_pkg::LEVELS-1];
	logic [mhpq_pkg::LEVELS-1:1]       cell_done;

	logic                              rsp_valid_q;
	mhpq_pkg::value_t                  rsp_top_q;
	logic                              rsp_empty_q;
	logic [mhpq_pkg::COUNT_OUT_W-1:0]  rsp_count_q;
	mhpq_pkg::status_t                 rsp_status_q;

	// Index of the leading one, which is the heap level of a slot given its index plus one.
	function automatic logic [mhpq_pkg::LVL_W-1:0] msb_index(
		input logic [mhpq_pkg::GIDX_W-1:0] x
	);
		logic [mhpq_pkg::LVL_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < mhpq_pkg::GIDX_W; i++) begin
			if (x[i]) begin
				idx = mhpq_pkg::LVL_W'(i);
			end
		end
		return idx;
	endfunction

	assign accept = req.valid && req.ready;

	// A push fills slot count, so its walk follows the bits of count plus one.
	// A pop first fetches the last entry, slot count minus one, whose index plus one
	// is count itself.
	always_comb begin
		np1       = mhpq_pkg::GIDX_W'(count_q) + mhpq_pkg::GIDX_W'(1);
		push_lvl  = msb_index(np1);
		fetch_lvl = msb_index(mhpq_pkg::GIDX_W'(count_q));

		push_tok.valid = 1'b1;
		push_tok.op    = mhpq_pkg::OP_PUSH;
		push_tok.carry = (req.value < root_q) ? root_q : req.value;
		push_tok.pos   = mhpq_pkg::POS_W'(np1[push_lvl - 1'b1]);
		push_tok.rem   = push_lvl - 1'b1;
		push_tok.path  = np1;
		push_tok.base  = mhpq_pkg::GIDX_W'(1);
		push_tok.count = count_q;

		pop_tok.valid  = 1'b1;
		pop_tok.op     = mhpq_pkg::OP_POP;
		pop_tok.carry  = rdat0[fetch_lvl_q];
		pop_tok.pos    = '0;
		pop_tok.rem    = '0;
		pop_tok.path   = '0;
		pop_tok.base   = mhpq_pkg::GIDX_W'(1);
		pop_tok.count  = count_q;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mhpq_pkg::S_IDLE: begin
				if (accept) begin
					if (req.operation == mhpq_pkg::OP_PUSH) begin
						if (count_q == mhpq_pkg::CNT_W'(mhpq_pkg::HEAP_DEPTH) || count_q == '0) begin
							state_d = mhpq_pkg::S_DONE;
						end else begin
							state_d = mhpq_pkg::S_RUN;
						end
					end else begin
						if (count_q <= mhpq_pkg::CNT_W'(1)) begin
							state_d = mhpq_pkg::S_DONE;
						end else begin
							state_d = mhpq_pkg::S_FETCH;
						end
					end
				end
			end
			mhpq_pkg::S_FETCH: begin
				state_d = (count_q > mhpq_pkg::CNT_W'(1)) ? mhpq_pkg::S_RUN : mhpq_pkg::S_DONE;
			end
			mhpq_pkg::S_RUN: begin
				if (|cell_done) begin
					state_d = mhpq_pkg::S_DONE;
				end
			end
			mhpq_pkg::S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = mhpq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mhpq_pkg::S_IDLE;
			end
		endcase
	end

	// Controller outputs.
	always_comb begin
		req.ready = (state_q == mhpq_pkg::S_IDLE);
		fetch_sel = (state_q == mhpq_pkg::S_IDLE);
		load_rsp  = (state_q == mhpq_pkg::S_DONE) && (!rsp_valid_q || rsp.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mhpq_pkg::S_IDLE;
			count_q  <= '0;
			launch_q <= '0;
		end else begin
			state_q        <= state_d;
			launch_q.valid <= 1'b0;
			if (accept) begin
				if (req.operation == mhpq_pkg::OP_PUSH) begin
					if (count_q != mhpq_pkg::CNT_W'(mhpq_pkg::HEAP_DEPTH)) begin
						count_q <= count_q + 1'b1;
						if (count_q != '0) begin
							launch_q <= push_tok;
						end
					end
				end else if (count_q != '0) begin
					count_q <= count_q - 1'b1;
				end
			end
			if (state_q == mhpq_pkg::S_FETCH && count_q > mhpq_pkg::CNT_W'(1)) begin
				launch_q <= pop_tok;
			end
		end
	end

	// Root, status and fetch level carry no reset: they are written before use.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= mhpq_pkg::ST_DONE;
			fetch_lvl_q <= fetch_lvl;
			if (req.operation == mhpq_pkg::OP_PUSH) begin
				if (count_q == mhpq_pkg::CNT_W'(mhpq_pkg::HEAP_DEPTH)) begin
					status_q <= mhpq_pkg::ST_FULL;
				end else if (count_q == '0 || req.value < root_q) begin
					root_q <= req.value;
				end
			end else if (count_q == '0) begin
				status_q <= mhpq_pkg::ST_EMPTY;
			end
		end
		// With one entry left after a pop, the fetched last entry becomes the root.
		if (state_q == mhpq_pkg::S_FETCH && count_q == mhpq_pkg::CNT_W'(1)) begin
			root_q <= rdat0[fetch_lvl_q];
		end
		if (bwr[1].en) begin
			root_q <= bwr[1].value;
		end
	end

	// Output register: the result is formed from the settled root and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_top_q    <= (count_q == '0) ? '0 : root_q;
			rsp_empty_q  <= (count_q == '0);
			rsp_count_q  <= mhpq_pkg::COUNT_OUT_W'(count_q);
			rsp_status_q <= status_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.top_value     = rsp_top_q;
	assign rsp.is_empty      = rsp_empty_q;
	assign rsp.entry_count   = rsp_count_q;
	assign rsp.result_status = rsp_status_q;

	// Row of level cells, each paired with the RAM of its level.
	assign tok[1]                   = launch_q;
	assign bwr[mhpq_pkg::LEVELS]    = '0;
	assign rdat0[0]                 = '0;

	for (genvar k = 1; k < mhpq_pkg::LEVELS; k++) begin : g_lvl
		logic [k-1:0] ra0;

		mhpq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1]),
			.bwr_in  (bwr[k+1]),
			.bwr_out (bwr[k]),
			.ram     (ram[k]),
			.rdata0  (rdat0[k]),
			.rdata1  (rdat1[k]),
			.done    (cell_done[k])
		);

		// While idle, port 0 serves the fetch of the last entry for a pop.
		assign ra0 = (fetch_sel && fetch_lvl == mhpq_pkg::LVL_W'(k)) ?
			count_q[k-1:0] : ram[k].raddr0[k-1:0];

		mhpq_ram #(
			.ADDR_W (k)
		) u_ram (
			.clk    (clk),
			.we     (ram[k].we),
			.waddr  (ram[k].waddr[k-1:0]),
			.wdata  (ram[k].wdata),
			.raddr0 (ra0),
			.raddr1 (ram[k].raddr1[k-1:0]),
			.rdata0 (rdat0[k]),
			.rdata1 (rdat1[k])
		);
	end

	// A request never runs past the deepest level.
	a_chain_end: assert property (@(posedge clk) disable iff (!arst_n)
		!tok[mhpq_pkg::LEVELS].valid)
		else $error("request left the deepest heap level");

	// The count never exceeds the capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mhpq_pkg::CNT_W'(mhpq_pkg::HEAP_DEPTH))
		else $error("entry count beyond capacity");

	// Cells only finish while the controller waits for them.
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(|cell_done) |-> (state_q == mhpq_pkg::S_RUN))
		else $error("level cell finished outside a running request");

	// The count moves only when a request is accepted.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mhpq_pkg::S_IDLE) |=> $stable(count_q))
		else $error("entry count changed while a request was in flight");

endmodule

### tb/mhpq_checker.sv
// Result checker for the min-heap priority queue: watches both channels, keeps its own heap
// image and compares every result with the oldest prediction.
// Depends on mhpq_pkg, mhpq_req_if and mhpq_rsp_if.
module mhpq_checker
	import mhpq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	mhpq_req_if   req,
	mhpq_rsp_if   rsp,
	output int    fail_count,
	output int    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		value_t                 top_value;
		logic                   is_empty;
		logic [COUNT_OUT_W-1:0] entry_count;
		status_t                result_status;
	} heap_result_t;

	value_t       heap_vals [HEAP_DEPTH];
	int           heap_fill;
	heap_result_t results_due [$];
	int           bad_results;
	int           results_seen;

	// Applies one request to the heap image and returns the result it must produce.
	function automatic heap_result_t apply_request(op_t op, value_t v);
		int           pos;
		int           kid;
		int           up;
		bit           moving;
		value_t       tmp;
		heap_result_t r;
		r.result_status = ST_DONE;
		if (op == OP_PUSH) begin
			if (heap_fill >= HEAP_DEPTH) begin
				r.result_status = ST_FULL;
			end else begin
				pos = heap_fill;
				heap_vals[pos] = v;
				heap_fill++;
				moving = 1'b1;
				while (moving && pos > 0) begin
					up = (pos - 1) / 2;
					if (heap_vals[pos] < heap_vals[up]) begin
						tmp = heap_vals[pos];
						heap_vals[pos] = heap_vals[up];
						heap_vals[up] = tmp;
						pos = up;
					end else begin
						moving = 1'b0;
					end
				end
			end
		end else begin
			if (heap_fill == 0) begin
				r.result_status = ST_EMPTY;
			end else begin
				heap_fill--;
				heap_vals[0] = heap_vals[heap_fill];
				pos = 0;
				moving = 1'b1;
				while (moving) begin
					kid = 2 * pos + 1;
					if (kid >= heap_fill) begin
						moving = 1'b0;
					end else begin
						// Right child only when strictly smaller; ties stay put.
						if (kid + 1 < heap_fill && heap_vals[kid + 1] < heap_vals[kid])
							kid++;
						if (heap_vals[kid] < heap_vals[pos]) begin
							tmp = heap_vals[kid];
							heap_vals[kid] = heap_vals[pos];
							heap_vals[pos] = tmp;
							pos = kid;
						end else begin
							moving = 1'b0;
						end
					end
				end
			end
		end
		r.top_value   = (heap_fill > 0) ? heap_vals[0] : '0;
		r.is_empty    = (heap_fill == 0);
		r.entry_count = COUNT_OUT_W'(heap_fill);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		heap_result_t want;
		if (!arst_n) begin
			heap_fill = 0;
			bad_results = 0;
			results_seen = 0;
			results_due.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// Results first: a result taken at this edge belongs to an older request.
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (results_due.size() == 0) begin
					if (bad_results < MAX_REPORTS)
						$display("result %0d arrived with no request pending", results_seen);
					bad_results++;
				end else begin
					want = results_due.pop_front();
					if (rsp.top_value !== want.top_value || rsp.is_empty !== want.is_empty ||
						rsp.entry_count !== want.entry_count ||
						rsp.result_status !== want.result_status) begin
						if (bad_results < MAX_REPORTS)
							$display({"result %0d mismatch: expected top=%0d empty=%0b ",
								"count=%0d status=%0d, got top=%0d empty=%0b count=%0d ",
								"status=%0d"}, results_seen, want.top_value, want.is_empty,
								want.entry_count, want.result_status, rsp.top_value,
								rsp.is_empty, rsp.entry_count, rsp.result_status);
						bad_results++;
					end
				end
			end
			if (req.valid && req.ready)
				results_due.push_back(apply_request(req.operation, req.value));
			fail_count <= bad_results;
			outstanding <= results_due.size();
		end
	end

endmodule

### tb/min_heap_priority_queue_test.sv
// Testbench top for the min-heap priority queue: clock, reset, request and result traffic,
// watchdog and verdict. Checking is done by mhpq_checker.
// Depends on mhpq_pkg, mhpq_req_if, mhpq_rsp_if, mhpq_checker and min_heap_priority_queue.
module min_heap_priority_queue_test;
	import mhpq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// The longest correct quiet stretch is the receiver hold-off plus one request and
	// a long gap; the limit leaves a wide margin over that.
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 40;

	localparam value_t VALUE_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};
	localparam value_t VALUE_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};

	logic clk;
	logic arst_n;

	mhpq_req_if req_ch ();
	mhpq_rsp_if rsp_ch ();

	int mismatches;
	int results_pending;
	int quiet_cycles;

	// Number of entries the heap should hold once every request sent so far is done.
	// It only steers the stimulus toward full and empty; checking is the checker's job.
	int heap_level;
	bit send_burst;
	bit take_burst;
	int results_taken;

	min_heap_priority_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	mhpq_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (mismatches),
		.outstanding (results_pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Idle length between handshakes: mostly none or a few cycles, now and then a long
	// one. During a burst there is no idling at all.
	function automatic int pick_gap(bit burst);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst || r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Values mix full-width random patterns (every bit toggles), a narrow band that
	// makes many ties, the extremes, and single set bits.
	function automatic value_t pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			6, 7: begin
				return value_t'($signed($urandom_range(0, 8)) - 4);
			end
			8: begin
				case ($urandom_range(0, 3))
					0: return VALUE_MIN;
					1: return VALUE_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			9: begin
				return value_t'(32'd1 << $urandom_range(0, VALUE_W - 1));
			end
			default: begin
				return value_t'($urandom);
			end
		endcase
	endfunction

	// Offers one request and waits for it to be taken, then idles for a random gap.
	// The valid is left high when no gap follows, so back-to-back requests never lower
	// and raise it within one step.
	task automatic send_request(op_t op, value_t v);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.value <= v;
		do
			@(posedge clk);
		while (!req_ch.ready);
		if (op == OP_PUSH && heap_level < HEAP_DEPTH)
			heap_level++;
		else if (op == OP_POP && heap_level > 0)
			heap_level--;
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		gap = pick_gap(send_burst);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// A run of random requests in which pop_pct percent are pops.
	task automatic send_mix(int count, int pop_pct);
		for (int i = 0; i < count; i++) begin
			send_request(($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_PUSH, pick_value());
		end
	endtask

	// Reset and request traffic. Reset is applied once, then a short directed part
	// covers the refusal of a pop from the empty heap, the extremes and ties; the random
	// part then works at low fill, fills the heap to the top so sifts run through every
	// level, knocks on the full heap, and finally runs mostly pops on the nearly full heap.
	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.operation <= OP_PUSH;
		req_ch.value <= '0;
		heap_level = 0;
		send_burst = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pop from the empty heap must be refused and report a zero top.
		send_request(OP_POP, value_t'($urandom));
		// Extremes of the value range, a minus one and a zero.
		send_request(OP_PUSH, '0);
		send_request(OP_PUSH, VALUE_MAX);
		send_request(OP_PUSH, VALUE_MIN);
		send_request(OP_PUSH, '1);
		// Equal values: ties must never swap, and equal children pick the left one.
		send_request(OP_PUSH, value_t'(5));
		send_request(OP_PUSH, value_t'(5));
		send_request(OP_PUSH, VALUE_MIN);
		send_request(OP_PUSH, value_t'(5));
		send_request(OP_PUSH, value_t'(5));
		// Drain everything, with one extra pop that hits the empty heap again.
		for (int i = 0; i < 10; i++)
			send_request(OP_POP, value_t'($urandom));
		// A second, smaller heap full of ties.
		send_request(OP_PUSH, value_t'(2));
		send_request(OP_PUSH, value_t'(2));
		send_request(OP_PUSH, value_t'(2));
		send_request(OP_PUSH, value_t'(1));
		send_request(OP_POP, '0);

		// Low fill, empty refusals come up by chance.
		send_mix(200, 45);
		// Climb to a full heap with only a few pops on the way.
		while (heap_level < HEAP_DEPTH)
			send_mix(1, 3);
		// The heap is full now: these pushes must be refused.
		send_request(OP_PUSH, pick_value());
		send_request(OP_PUSH, VALUE_MIN);
		send_mix(16, 30);
		// Deep pops on a nearly full heap.
		send_mix(150, 75);

		// Wait for the next edge so the pending count covers the last request, then until
		// every result is in, then a little longer to catch any stray result.
		if (req_ch.valid)
			req_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && results_pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Result side: takes results with random stalls of its own. Twice it holds off for
	// a long stretch while requests keep coming, so the block fills its result register,
	// stops accepting and has to resume cleanly afterwards.
	initial begin
		int gap;
		rsp_ch.ready <= 1'b0;
		take_burst = 1'b0;
		results_taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_ch.valid);
			results_taken++;
			if ($urandom_range(0, 39) == 0)
				take_burst = !take_burst;
			if (results_taken == 150 || results_taken == 700) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = pick_gap(take_burst);
				if (gap > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Watchdog: a long run of edges with no handshake on either channel means the
	// block has hung or lost a result.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
